@@ rtl/core/xsfb_pkg.sv @@
// xsfb_pkg: shared constants, types and lookup tables for the xor sprite framebuffer
// no dependencies; imported by the controller, the datapath and the top level
package xsfb_pkg;

  localparam int unsigned SCREEN_WIDTH  = 64;
  localparam int unsigned SCREEN_HEIGHT = 32;
  localparam int unsigned SPRITE_BITS   = 8;

  localparam int unsigned XW = $clog2(SCREEN_WIDTH);
  localparam int unsigned YW = $clog2(SCREEN_HEIGHT);

  localparam logic FUNC_DRAW  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef logic [SCREEN_WIDTH-1:0] word_t;
  typedef logic [7:0] mod_tbl_t [256];

  // controller to datapath
  typedef struct packed {
    logic load;   // latch item, issue row read
    logic exec;   // xor row, write back, load result
  } xsfb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy; // result register full and not taken this cycle
  } xsfb_status_t;

  // residue table built at elaboration by counting, v mod m for v in 0..255
  function automatic mod_tbl_t build_mod_tbl(int unsigned m);
    mod_tbl_t    t;
    int unsigned r;
    r = 0;
    for (int v = 0; v < 256; v++) begin
      t[v] = 8'(r);
      if (r == m - 1) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return t;
  endfunction

  localparam mod_tbl_t XMOD_TBL = build_mod_tbl(SCREEN_WIDTH);
  localparam mod_tbl_t YMOD_TBL = build_mod_tbl(SCREEN_HEIGHT);

endpackage

@@ rtl/core/xsfb_if.sv @@
// xsfb channel interfaces: sprite row input, result output, configuration write
// no dependencies; used by the top level ports
interface xsfb_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [3:0] row_index;
  logic [7:0] row_bits;
  logic       last_row;

  modport source (output valid, func, x_pos, y_pos, row_index, row_bits, last_row,
                  input ready);
  modport sink (input valid, func, x_pos, y_pos, row_index, row_bits, last_row,
                output ready);
endinterface

interface xsfb_out_if;
  logic valid;
  logic ready;
  logic collision;
  logic sprite_done;

  modport source (output valid, collision, sprite_done, input ready);
  modport sink (input valid, collision, sprite_done, output ready);
endinterface

interface xsfb_cfg_if;
  logic valid;
  logic ready;
  logic wrap_enable;

  modport source (output valid, wrap_enable, input ready);
  modport sink (input valid, wrap_enable, output ready);
endinterface

@@ rtl/core/xor_sprite_framebuffer_top.sv @@
// xor_sprite_framebuffer_top: chip8-style xor sprite framebuffer, controller plus datapath
// depends on xsfb_pkg, xsfb_if, xsfb_ctrl, xsfb_dp
//
//   channel  dir  word                                             handshake
//   in_i     in   func x_pos y_pos row_index row_bits last_row     valid/ready
//   out_o    out  collision sprite_done                            valid/ready
//   cfg_i    in   wrap_enable                                      valid/ready, ready tied high
//
// each word is accepted at an edge that reads the target row word from the row memory; then,
// in S_EXEC, the sprite mask is xored in, the row is written back and the result register loaded
// a clear goes through the same steps: per-row valid flops drop at once, no sweep after reset
// the result register frees the input side; the S_EXEC step waits only while a previous
// result is still held and not taken
module xor_sprite_framebuffer_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  xsfb_in_if.sink    in_i,
  xsfb_out_if.source out_o,
  xsfb_cfg_if.sink   cfg_i
);
  import xsfb_pkg::*;

  xsfb_cmd_t    cmd;
  xsfb_status_t status;

  assign cfg_i.ready = 1'b1;

  xsfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  xsfb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_i.valid),
    .cfg_wrap_i    (cfg_i.wrap_enable),
    .func_i        (in_i.func),
    .x_pos_i       (in_i.x_pos),
    .y_pos_i       (in_i.y_pos),
    .row_index_i   (in_i.row_index),
    .row_bits_i    (in_i.row_bits),
    .last_row_i    (in_i.last_row),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .collision_o   (out_o.collision),
    .sprite_done_o (out_o.sprite_done)
  );

`ifndef NO_ASSERTIONS
  // one word in flight: no second accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while a word is in flight");

  // a write-back never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> !(out_o.valid && !out_o.ready))
    else $error("result register overwritten");

  // every executed word shows up as a result on the next cycle
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> out_o.valid)
    else $error("executed word produced no result");
`endif

endmodule

@@ rtl/core/xsfb_ctrl.sv @@
// xsfb_ctrl: two-state sequencer, accept a word then run the row read-modify-write
// depends on xsfb_pkg
module xsfb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  xsfb_pkg::xsfb_status_t status_i,
  output xsfb_pkg::xsfb_cmd_t   cmd_o
);
  import xsfb_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.load = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec = (state_q == S_EXEC) && !status_i.out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          // hold while the result register cannot take a new word
          if (!status_i.out_busy) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/xsfb_dp.sv @@
// xsfb_dp: row memory, coordinate reduction, xor mask, collision flag, result register
// depends on xsfb_pkg
module xsfb_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  xsfb_pkg::xsfb_cmd_t    cmd_i,
  output xsfb_pkg::xsfb_status_t status_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wrap_i,
  input  logic                   func_i,
  input  logic [7:0]             x_pos_i,
  input  logic [7:0]             y_pos_i,
  input  logic [3:0]             row_index_i,
  input  logic [7:0]             row_bits_i,
  input  logic                   last_row_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   collision_o,
  output logic                   sprite_done_o
);
  import xsfb_pkg::*;

  word_t                   mem_q [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] row_valid_q;
  word_t                   rdata_q;

  logic          wrap_q;
  logic          coll_q;
  logic          func_q;
  logic [7:0]    x_q;
  logic [XW-1:0] xm_q;
  logic [YW-1:0] row_q;
  logic          row_ok_q;
  logic [7:0]    bits_q;
  logic          last_q;

  logic out_valid_q;
  logic out_coll_q;
  logic out_done_q;

  // row address from the incoming word
  logic [8:0]    y_sum;
  logic [YW:0]   y_wsum;
  logic [YW:0]   y_wred;
  logic [YW-1:0] row_d;
  logic          row_ok_d;

  always_comb begin
    y_sum  = {1'b0, y_pos_i} + {5'b0, row_index_i};
    y_wsum = {1'b0, YMOD_TBL[y_pos_i][YW-1:0]} + {1'b0, YMOD_TBL[{4'b0, row_index_i}][YW-1:0]};
    if (y_wsum >= (YW+1)'(SCREEN_HEIGHT)) begin
      y_wred = y_wsum - (YW+1)'(SCREEN_HEIGHT);
    end else begin
      y_wred = y_wsum;
    end
    if (wrap_q) begin
      row_d    = y_wred[YW-1:0];
      row_ok_d = 1'b1;
    end else begin
      row_d    = y_sum[YW-1:0];
      row_ok_d = (y_sum < 9'(SCREEN_HEIGHT));
    end
  end

  // xor mask for the eight sprite pixels, columns are distinct so or-ing is exact
  word_t         mask;
  word_t         cur_word;
  logic [XW:0]   col_w;
  logic [8:0]    col_c;
  logic          hit;
  logic          coll_new;

  always_comb begin
    mask  = '0;
    col_w = '0;
    col_c = '0;
    for (int i = 0; i < SPRITE_BITS; i++) begin
      if (bits_q[SPRITE_BITS-1-i]) begin
        if (wrap_q) begin
          col_w = {1'b0, xm_q} + (XW+1)'(i);
          if (col_w >= (XW+1)'(SCREEN_WIDTH)) col_w = col_w - (XW+1)'(SCREEN_WIDTH);
          mask = mask | (word_t'(1) << col_w[XW-1:0]);
        end else begin
          col_c = {1'b0, x_q} + 9'(i);
          if (col_c < 9'(SCREEN_WIDTH)) mask = mask | (word_t'(1) << col_c[XW-1:0]);
        end
      end
    end
  end

  // rows never written since reset or clear read as blank
  assign cur_word = row_valid_q[row_q] ? rdata_q : '0;
  assign hit      = row_ok_q && |(cur_word & mask);
  assign coll_new = coll_q | hit;

  assign status_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rdata_q  <= mem_q[row_d];
      func_q   <= func_i;
      x_q      <= x_pos_i;
      xm_q     <= XMOD_TBL[x_pos_i][XW-1:0];
      row_q    <= row_d;
      row_ok_q <= row_ok_d;
      bits_q   <= row_bits_i;
      last_q   <= last_row_i;
    end
    if (cmd_i.exec && (func_q == FUNC_DRAW) && row_ok_q) begin
      mem_q[row_q] <= cur_word ^ mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q      <= 1'b0;
      coll_q      <= 1'b0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
      out_coll_q  <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) wrap_q <= cfg_wrap_i;
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
        if (func_q == FUNC_CLEAR) begin
          row_valid_q <= '0;
          coll_q      <= 1'b0;
          out_coll_q  <= 1'b0;
          out_done_q  <= 1'b1;
        end else begin
          if (row_ok_q) row_valid_q[row_q] <= 1'b1;
          coll_q     <= last_q ? 1'b0 : coll_new;
          out_coll_q <= coll_new;
          out_done_q <= last_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign collision_o   = out_coll_q;
  assign sprite_done_o = out_done_q;

endmodule

@@ bench/xor_sprite_framebuffer_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for xor_sprite_framebuffer_top: sprite rows in, collision/done flags out
// keeps its own copy of the screen and predicts each result word; needs xsfb_pkg and xsfb_if
module xor_sprite_framebuffer_top_tb;
  import xsfb_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct packed {
    logic       func;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [3:0] row_index;
    logic [7:0] row_bits;
    logic       last_row;
  } sprite_row_t;

  typedef struct packed {
    logic collision;
    logic sprite_done;
  } draw_flags_t;

  logic clk_i;
  logic rst_ni;

  xsfb_in_if  in_if ();
  xsfb_out_if out_if ();
  xsfb_cfg_if cfg_if ();

  xor_sprite_framebuffer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // shadow screen and sprite state
  word_t       screen_copy [SCREEN_HEIGHT];
  logic        erase_hit;
  logic        wrap_mode;
  draw_flags_t expected_flags [$];

  int unsigned rows_sent;
  int unsigned flags_checked;
  int unsigned collisions_checked;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned stall_left;
  bit          calm;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic sprite_row_t mk_row(logic func, logic [7:0] x, logic [7:0] y,
                                         logic [3:0] ri, logic [7:0] bits, logic last);
    sprite_row_t r;
    r.func      = func;
    r.x_pos     = x;
    r.y_pos     = y;
    r.row_index = ri;
    r.row_bits  = bits;
    r.last_row  = last;
    return r;
  endfunction

  function automatic draw_flags_t xor_row_into_screen(sprite_row_t it);
    draw_flags_t r;
    int unsigned row;
    int unsigned col;
    int unsigned i;
    bit          row_ok;
    word_t       w;
    if (it.func == FUNC_CLEAR) begin
      foreach (screen_copy[k]) screen_copy[k] = '0;
      erase_hit     = 1'b0;
      r.collision   = 1'b0;
      r.sprite_done = 1'b1;
      return r;
    end
    row    = it.y_pos + it.row_index;
    row_ok = 1'b1;
    if (wrap_mode) begin
      row = row % SCREEN_HEIGHT;
    end else if (row >= SCREEN_HEIGHT) begin
      row_ok = 1'b0;
    end
    if (row_ok) begin
      w = screen_copy[row];
      for (i = 0; i < SPRITE_BITS; i++) begin
        if (it.row_bits[SPRITE_BITS-1-i]) begin
          col = it.x_pos + i;
          if (wrap_mode) begin
            col = col % SCREEN_WIDTH;
          end
          if (col < SCREEN_WIDTH) begin
            if (w[col]) erase_hit = 1'b1;
            w[col] = ~w[col];
          end
        end
      end
      screen_copy[row] = w;
    end
    r.collision   = erase_hit;
    r.sprite_done = it.last_row;
    if (it.last_row) erase_hit = 1'b0;
    return r;
  endfunction

  // offer one word, optionally after a short gap, and predict it once taken
  task automatic send_row(sprite_row_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= it.func;
    in_if.x_pos     <= it.x_pos;
    in_if.y_pos     <= it.y_pos;
    in_if.row_index <= it.row_index;
    in_if.row_bits  <= it.row_bits;
    in_if.last_row  <= it.last_row;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_flags.push_back(xor_row_into_screen(it));
    rows_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_wrap(logic on);
    drain_results();
    cfg_if.valid       <= 1'b1;
    cfg_if.wrap_enable <= on;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    wrap_mode = on;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sprite(bit wide);
    logic [7:0]  x;
    logic [7:0]  y;
    int unsigned rows;
    int unsigned k;
    bit          broken;
    x      = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 70));
    y      = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 40));
    rows   = $urandom_range(1, 16);
    broken = ($urandom_range(0, 9) == 0);
    for (k = 0; k < rows; k++) begin
      if (broken && $urandom_range(0, 3) == 0) begin
        send_row(mk_row(FUNC_DRAW, x, y, 4'($urandom), 8'($urandom), 1'($urandom)));
      end else begin
        send_row(mk_row(FUNC_DRAW, x, y, 4'(k), 8'($urandom), !broken && k == rows - 1));
      end
    end
  endtask

  task automatic test_clip_edges();
    set_wrap(1'b0);
    send_row(mk_row(FUNC_CLEAR, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0));
    send_row(mk_row(FUNC_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b1));
    send_row(mk_row(FUNC_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b1));
    // three-row sprite, then a second pass that redraws only its middle row: erase, flag sticks across rows
    send_row(mk_row(FUNC_DRAW, 8'd10, 8'd5, 4'd0, 8'hA5, 1'b0));
    send_row(mk_row(FUNC_DRAW, 8'd10, 8'd5, 4'd1, 8'h3C, 1'b0));
    send_row(mk_row(FUNC_DRAW, 8'd10, 8'd5, 4'd2, 8'h81, 1'b1));
    send_row(mk_row(FUNC_DRAW, 8'd10, 8'd5, 4'd0, 8'h00, 1'b0));
    send_row(mk_row(FUNC_DRAW, 8'd10, 8'd5, 4'd1, 8'h3C, 1'b0));
    send_row(mk_row(FUNC_DRAW, 8'd10, 8'd5, 4'd2, 8'h00, 1'b1));
    // right and bottom edges drop pixels
    send_row(mk_row(FUNC_DRAW, 8'd60, 8'd31, 4'd0, 8'hFF, 1'b1));
    send_row(mk_row(FUNC_DRAW, 8'd255, 8'd3, 4'd0, 8'hFF, 1'b1));
    send_row(mk_row(FUNC_DRAW, 8'd0, 8'd20, 4'd15, 8'hFF, 1'b0));
    send_row(mk_row(FUNC_DRAW, 8'd0, 8'd255, 4'd15, 8'hFF, 1'b1));
    send_row(mk_row(FUNC_DRAW, 8'd56, 8'd31, 4'd0, 8'hFF, 1'b1));
  endtask

  task automatic test_wrap_edges();
    set_wrap(1'b1);
    send_row(mk_row(FUNC_DRAW, 8'd60, 8'd0, 4'd0, 8'hFF, 1'b1));
    send_row(mk_row(FUNC_DRAW, 8'd124, 8'd32, 4'd0, 8'h0F, 1'b1));
    send_row(mk_row(FUNC_DRAW, 8'd255, 8'd255, 4'd15, 8'hFF, 1'b0));
    send_row(mk_row(FUNC_DRAW, 8'd63, 8'd14, 4'd0, 8'h80, 1'b1));
    send_row(mk_row(FUNC_DRAW, 8'd200, 8'd100, 4'd7, 8'h55, 1'b1));
    send_row(mk_row(FUNC_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1));
    send_row(mk_row(FUNC_DRAW, 8'd255, 8'd255, 4'd15, 8'hFF, 1'b1));
  endtask

  task automatic test_output_backpressure();
    int unsigned k;
    hold_request = 80;
    for (k = 0; k < 24; k++) begin
      send_row(mk_row(FUNC_DRAW, 8'($urandom_range(0, 63)), 8'($urandom_range(0, 31)),
                      4'($urandom), 8'($urandom), 1'($urandom)));
    end
    drain_results();
  endtask

  task automatic test_random_sprites();
    int unsigned phase;
    int unsigned target;
    int unsigned pick;
    bit          paused;
    logic        wrap_plan [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    for (phase = 0; phase < 6; phase++) begin
      set_wrap(wrap_plan[phase]);
      calm   = (phase == 5);
      target = rows_sent + 110;
      paused = 1'b0;
      while (rows_sent < target) begin
        // sender stops until the block has handed back everything
        if (phase == 2 && !paused && rows_sent + 55 >= target) begin
          drain_results();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_row(mk_row(FUNC_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom)));
        end else if (pick < 12) begin
          send_row(mk_row(FUNC_DRAW, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom)));
        end else begin
          send_sprite($urandom_range(0, 3) == 0);
        end
      end
    end
  endtask

  // result side: random stall bursts plus the long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    draw_flags_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_flags.size() == 0) begin
        $display("%0t: result word with nothing expected: collision=%b sprite_done=%b",
                 $time, out_if.collision, out_if.sprite_done);
        mismatches++;
      end else begin
        want = expected_flags.pop_front();
        flags_checked++;
        if (want.collision) collisions_checked++;
        if (out_if.collision !== want.collision) begin
          $display("%0t: collision expected %b got %b", $time, want.collision,
                   out_if.collision);
          mismatches++;
        end
        if (out_if.sprite_done !== want.sprite_done) begin
          $display("%0t: sprite_done expected %b got %b", $time, want.sprite_done,
                   out_if.sprite_done);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("xor_sprite_framebuffer_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.func         = FUNC_DRAW;
    in_if.x_pos        = '0;
    in_if.y_pos        = '0;
    in_if.row_index    = '0;
    in_if.row_bits     = '0;
    in_if.last_row     = 1'b0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.wrap_enable = 1'b0;
    foreach (screen_copy[k]) screen_copy[k] = '0;
    erase_hit          = 1'b0;
    wrap_mode          = 1'b0;
    rows_sent          = 0;
    flags_checked      = 0;
    collisions_checked = 0;
    mismatches         = 0;
    quiet_cycles       = 0;
    hold_request       = 0;
    hold_left          = 0;
    stall_left         = 0;
    calm               = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_clip_edges();
    test_wrap_edges();
    test_output_backpressure();
    test_random_sprites();

    drain_results();
    repeat (5) @(posedge clk_i);
    $display("run: %0d sprite rows and clears sent, %0d result words checked, %0d with collision",
             rows_sent, flags_checked, collisions_checked);
    $display("covered clip and wrap modes, edge coordinates, long output hold and a drained pause");
    if (mismatches == 0) begin
      $display("xor_sprite_framebuffer_top regression: pass");
    end else begin
      $display("xor_sprite_framebuffer_top regression: fail");
    end
    $finish;
  end

endmodule
